@@ rtl/ile_pkg.sv @@
// Package for the indexed list engine: sizes, operation and status codes,
// sequencer states and the RAM write port bundle. No dependencies.
package ile_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = 8;   // entry address, CAPACITY entries
  localparam int LEN_W    = 9;   // length 0..CAPACITY
  localparam int DATA_W   = 32;

  localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_HEAD   = 3'd1;
  localparam logic [2:0] OP_TAIL   = 3'd2;
  localparam logic [2:0] OP_INSERT = 3'd3;
  localparam logic [2:0] OP_DELETE = 3'd4;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDDATA,  // read operation: RAM data arrives
    S_RD,      // shift: fetch source entry
    S_WR,      // shift: store it one place over
    S_PUT,     // insert: store the new value
    S_DONE     // hand result to the output register
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } ram_wr_t;

endpackage

@@ rtl/indexed_list_engine.sv @@
// Indexed list engine top level: request decode, shift sequencer, result
// register. Depends on ile_pkg and ile_ram.
//
//  channel | dir | tdata (low bit up)                  | tuser
//  in_     | in  | position[8:0], item_value[40:9]     | operation[2:0]
//  out_    | out | read_value[31:0], list_length[40:32]| status[1:0]
//
// One request at a time. A read passes through S_RDDATA and then S_DONE, its RAM data
// held in res_rv_r until the output register takes it; a rejected request goes straight
// to S_DONE. Insert and delete move one entry at a time, alternating S_RD and S_WR,
// through the single RAM port pair and step counter; an insert then stores the new
// value in S_PUT. Reset (rst_n low, synchronous) empties the list; entry
// contents are not cleared. A stalled output holds the finished result in S_DONE.
module indexed_list_engine
  import ile_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // position[8:0], item_value[40:9], zero pad
  input  logic [2:0]  in_tuser,   // operation[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // read_value[31:0], list_length[40:32], zero pad
  output logic [1:0]  out_tuser   // status[1:0]
);

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;        // shift cursor: destination address
  logic [ADDR_W-1:0] limit_r, limit_nxt;
  logic              is_ins_r, is_ins_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [DATA_W-1:0] res_rv_r, res_rv_nxt;
  logic [1:0]        res_st_r, res_st_nxt;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_rv_r;
  logic [1:0]        out_st_r;
  logic [LEN_W-1:0]  out_len_r;

  logic [2:0]        in_op;
  logic [LEN_W-1:0]  in_pos;
  logic [DATA_W-1:0] in_val;
  logic              in_fire;
  logic [LEN_W-1:0]  ins_pos;
  logic [ADDR_W-1:0] k_step;            // shared step unit
  logic              out_load;

  ram_wr_t           ram_wr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  assign in_op   = in_tuser;
  assign in_pos  = in_tdata[8:0];
  assign in_val  = in_tdata[40:9];
  assign in_fire = in_tvalid & in_tready;

  // insert moves toward lower addresses, delete toward higher
  assign k_step = is_ins_r ? (k_r - ADDR_W'(1)) : (k_r + ADDR_W'(1));

  always_comb begin
    unique case (in_op)
      OP_HEAD: ins_pos = '0;
      OP_TAIL: ins_pos = len_r;
      default: ins_pos = in_pos;
    endcase
  end

  ile_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state and datapath
  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    k_nxt      = k_r;
    limit_nxt  = limit_r;
    is_ins_nxt = is_ins_r;
    val_nxt    = val_r;
    res_rv_nxt = res_rv_r;
    res_st_nxt = res_st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          val_nxt    = in_val;
          res_rv_nxt = '0;
          res_st_nxt = ST_DONE;
          state_nxt  = S_DONE;
          unique case (in_op)
            OP_READ: begin
              if (in_pos < len_r) begin
                state_nxt = S_RDDATA;
              end else begin
                res_rv_nxt = '1;
                res_st_nxt = ST_INVALID;
              end
            end
            OP_HEAD, OP_TAIL, OP_INSERT: begin
              is_ins_nxt = 1'b1;
              if (ins_pos > len_r) begin
                res_st_nxt = ST_INVALID;
              end else if (len_r == CAP_LEN) begin
                res_st_nxt = ST_FULL;
              end else begin
                // length below capacity here, so both fit the address width
                k_nxt     = len_r[ADDR_W-1:0];
                limit_nxt = ins_pos[ADDR_W-1:0];
                state_nxt = (len_r == ins_pos) ? S_PUT : S_RD;
              end
            end
            OP_DELETE: begin
              is_ins_nxt = 1'b0;
              if (in_pos < len_r) begin
                k_nxt     = in_pos[ADDR_W-1:0];
                limit_nxt = ADDR_W'(len_r - LEN_W'(1));
                if (in_pos == len_r - LEN_W'(1)) begin
                  len_nxt = len_r - LEN_W'(1);
                end else begin
                  state_nxt = S_RD;
                end
              end else begin
                res_st_nxt = ST_INVALID;
              end
            end
            default: res_st_nxt = ST_INVALID;
          endcase
        end
      end
      S_RDDATA: begin
        res_rv_nxt = ram_rdata;
        state_nxt  = S_DONE;
      end
      S_RD: state_nxt = S_WR;
      S_WR: begin
        k_nxt = k_step;
        if (k_step != limit_r) begin
          state_nxt = S_RD;
        end else if (is_ins_r) begin
          state_nxt = S_PUT;
        end else begin
          len_nxt   = len_r - LEN_W'(1);
          state_nxt = S_DONE;
        end
      end
      S_PUT: begin
        len_nxt   = len_r + LEN_W'(1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready    = 1'b0;
    ram_wr.we    = 1'b0;
    ram_wr.addr  = k_r;
    ram_wr.data  = ram_rdata;
    ram_raddr    = k_step;
    out_load     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        ram_raddr = in_pos[ADDR_W-1:0];
      end
      S_WR: ram_wr.we = 1'b1;
      S_PUT: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = limit_r;
        ram_wr.data = val_r;
      end
      S_DONE: out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    limit_r  <= limit_nxt;
    is_ins_r <= is_ins_nxt;
    val_r    <= val_nxt;
    res_rv_r <= res_rv_nxt;
    res_st_r <= res_st_nxt;
    if (out_load) begin
      out_rv_r  <= res_rv_r;
      out_st_r  <= res_st_r;
      out_len_r <= len_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_len_r, out_rv_r};
  assign out_tuser  = out_st_r;

endmodule

@@ rtl/ile_ram.sv @@
// Entry store of the indexed list engine: one write port, one read port
// with registered read data. Depends on ile_pkg.
module ile_ram
  import ile_pkg::*;
(
  input  logic              clk,
  input  ram_wr_t           wr,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for indexed_list_engine: directed table, then biased random
// grow/shrink/mix phases, results checked against the table or an in-bench list predictor.
// Depends on ile_pkg and the engine RTL.
module testbench;
  import ile_pkg::*;

  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam int RANDOM_ITEMS = 1526;
  localparam int SETTLE_CYCLES = 600;      // longer than the slowest shift
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int MAX_PRINTED = 40;

  localparam int PH_GROW = 0;
  localparam int PH_SHRINK = 1;
  localparam int PH_MIX = 2;

  typedef struct packed {
    logic [31:0]      rd;
    logic [1:0]       st;
    logic [LEN_W-1:0] len;
  } list_result_t;

  typedef struct {
    logic [2:0]   op;
    logic [8:0]   pos;
    logic [31:0]  val;
    bit           typed;
    list_result_t want;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;

  indexed_list_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  logic [31:0]  shadow_list[$];
  list_result_t pending_results[$];
  list_result_t oldest;

  bit steady_run = 1'b0;
  int errors = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int full_rejects = 0;
  int invalid_requests = 0;
  int times_filled = 0;
  int cycles = 0;

  // Typed rows start from an empty list; the rest rely on the predictor.
  directed_row_t directed_rows [24] = '{
    '{OP_READ,   9'd0,   32'h0000_0000, 1'b1, {32'hFFFF_FFFF, ST_INVALID, 9'd0}},
    '{OP_DELETE, 9'd0,   32'h0000_0000, 1'b1, {32'h0000_0000, ST_INVALID, 9'd0}},
    '{OP_INSERT, 9'd1,   32'h0000_1234, 1'b1, {32'h0000_0000, ST_INVALID, 9'd0}},
    '{OP_RSVD5,  9'd511, 32'hFFFF_FFFF, 1'b1, {32'h0000_0000, ST_INVALID, 9'd0}},
    '{OP_RSVD6,  9'd0,   32'h8000_0000, 1'b1, {32'h0000_0000, ST_INVALID, 9'd0}},
    '{OP_RSVD7,  9'd256, 32'h7FFF_FFFF, 1'b1, {32'h0000_0000, ST_INVALID, 9'd0}},
    '{OP_INSERT, 9'd0,   32'h0000_0000, 1'b1, {32'h0000_0000, ST_DONE,    9'd1}},
    '{OP_HEAD,   9'd511, 32'h7FFF_FFFF, 1'b1, {32'h0000_0000, ST_DONE,    9'd2}},
    '{OP_TAIL,   9'd0,   32'h8000_0000, 1'b1, {32'h0000_0000, ST_DONE,    9'd3}},
    '{OP_INSERT, 9'd3,   32'hFFFF_FFFF, 1'b1, {32'h0000_0000, ST_DONE,    9'd4}},
    '{OP_READ,   9'd0,   32'h0000_0000, 1'b1, {32'h7FFF_FFFF, ST_DONE,    9'd4}},
    '{OP_READ,   9'd2,   32'h0000_0000, 1'b1, {32'h8000_0000, ST_DONE,    9'd4}},
    '{OP_READ,   9'd3,   32'h0000_0000, 1'b1, {32'hFFFF_FFFF, ST_DONE,    9'd4}},
    '{OP_READ,   9'd4,   32'h0000_0000, 1'b1, {32'hFFFF_FFFF, ST_INVALID, 9'd4}},
    '{OP_READ,   9'd511, 32'h0000_0000, 1'b1, {32'hFFFF_FFFF, ST_INVALID, 9'd4}},
    '{OP_INSERT, 9'd5,   32'h0000_00FF, 1'b1, {32'h0000_0000, ST_INVALID, 9'd4}},
    '{OP_DELETE, 9'd4,   32'h0000_0000, 1'b1, {32'h0000_0000, ST_INVALID, 9'd4}},
    '{OP_DELETE, 9'd511, 32'h0000_0000, 1'b1, {32'h0000_0000, ST_INVALID, 9'd4}},
    '{OP_INSERT, 9'd2,   32'h0000_00A5, 1'b0, '0},
    '{OP_DELETE, 9'd0,   32'h0000_0000, 1'b0, '0},
    '{OP_READ,   9'd1,   32'h0000_0000, 1'b0, '0},
    '{OP_DELETE, 9'd3,   32'h0000_0000, 1'b0, '0},
    '{OP_HEAD,   9'd7,   32'h5A5A_5A5A, 1'b0, '0},
    '{OP_READ,   9'd0,   32'h0000_0000, 1'b0, '0}
  };

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= steady_run || ($urandom_range(0, 99) >= 26);
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("ERROR @%0d: %s", cycles, msg);
  endtask

  // Applies one request to the shadow list and returns what the engine must answer.
  function automatic list_result_t apply_list_op(input logic [2:0] op,
                                                 input logic [8:0] pos,
                                                 input logic [31:0] val);
    list_result_t r;
    int at;
    r.rd = '0;
    r.st = ST_DONE;
    at = int'(pos);
    case (op)
      OP_READ: begin
        if (at < shadow_list.size()) begin
          r.rd = shadow_list[at];
        end else begin
          r.rd = '1;
          r.st = ST_INVALID;
        end
      end
      OP_HEAD, OP_TAIL, OP_INSERT: begin
        if (op == OP_HEAD) at = 0;
        else if (op == OP_TAIL) at = shadow_list.size();
        // position check wins over the full check
        if (at > shadow_list.size()) r.st = ST_INVALID;
        else if (shadow_list.size() >= CAPACITY) r.st = ST_FULL;
        else shadow_list.insert(at, val);
      end
      OP_DELETE: begin
        if (at < shadow_list.size()) shadow_list.delete(at);
        else r.st = ST_INVALID;
      end
      default: r.st = ST_INVALID;
    endcase
    r.len = LEN_W'(shadow_list.size());
    return r;
  endfunction

  task automatic push_request(input logic [2:0] op, input logic [8:0] pos,
                              input logic [31:0] val, input bit typed,
                              input list_result_t want);
    list_result_t pred;
    int prev_len;
    if (!steady_run && $urandom_range(0, 99) < 26) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 26);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, val, pos};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    prev_len = shadow_list.size();
    pred = apply_list_op(op, pos, val);
    pending_results.push_back(typed ? want : pred);
    requests_sent++;
    if (pred.st == ST_FULL) full_rejects++;
    if (pred.st == ST_INVALID) invalid_requests++;
    if (prev_len < CAPACITY && shadow_list.size() == CAPACITY) times_filled++;
  endtask

  // Sender holds off until the engine has answered everything.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Insert share is tilted by phase so the list swings between empty and full.
  task automatic send_random(input int phase_kind);
    logic [2:0]  op;
    logic [8:0]  pos;
    logic [31:0] val;
    int len;
    int roll;
    int insert_top;
    len = shadow_list.size();
    roll = $urandom_range(0, 99);
    pos = 9'($urandom_range(0, 511));
    val = pick_value();
    insert_top = (phase_kind == PH_GROW) ? 95 : (phase_kind == PH_SHRINK) ? 40 : 60;
    if (roll < 8) begin
      op = 3'($urandom_range(0, 7));
    end else if (roll < 23) begin
      op = OP_READ;
      if (len > 0) pos = 9'($urandom_range(0, len - 1));
    end else if (roll < insert_top) begin
      case ($urandom_range(0, 2))
        0: op = OP_HEAD;
        1: op = OP_TAIL;
        default: begin
          op = OP_INSERT;
          pos = 9'($urandom_range(0, len));
        end
      endcase
    end else begin
      op = OP_DELETE;
      if (len > 0) pos = 9'($urandom_range(0, len - 1));
    end
    push_request(op, pos, val, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result tdata=%h tuser=%h", out_tdata, out_tuser));
      end else begin
        oldest = pending_results.pop_front();
        if (out_tdata[31:0] !== oldest.rd)
          report_mismatch($sformatf("read_value %h, want %h", out_tdata[31:0], oldest.rd));
        if (out_tuser !== oldest.st)
          report_mismatch($sformatf("status %0d, want %0d", out_tuser, oldest.st));
        if (out_tdata[40:32] !== oldest.len)
          report_mismatch($sformatf("list_length %0d, want %0d", out_tdata[40:32], oldest.len));
      end
    end
  end

  initial begin
    int phase;
    int at_edge;
    int total;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      push_request(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].val,
                   directed_rows[i].typed, directed_rows[i].want);

    total = requests_sent + RANDOM_ITEMS;
    phase = 0;
    while (requests_sent < total) begin
      drain_results();
      steady_run = (phase % 3 == PH_MIX);
      at_edge = 0;
      case (phase % 3)
        PH_GROW: begin
          while (at_edge < 16 && requests_sent < total) begin
            send_random(PH_GROW);
            if (shadow_list.size() == CAPACITY) at_edge++;
          end
        end
        PH_SHRINK: begin
          while (at_edge < 8 && requests_sent < total) begin
            send_random(PH_SHRINK);
            if (shadow_list.size() == 0) at_edge++;
          end
        end
        default: begin
          repeat (200) if (requests_sent < total) send_random(PH_MIX);
        end
      endcase
      phase++;
    end
    steady_run = 1'b0;

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d requests, %0d results checked over %0d phases", requests_sent,
             results_checked, phase);
    $display("list filled %0d times, %0d full rejects, %0d invalid requests",
             times_filled, full_rejects, invalid_requests);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_results.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
